### design/lps_pkg.sv
// Package: shared types, request codes and constants of the latency percentile block.
`timescale 1ns / 1ps

package lps_pkg;

   localparam int CAPACITY_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   // request codes
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_REPORT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // nearest-rank percentiles: pos = ceil(n*k/100) - 1
   localparam int NUM_PCT = 3;
   localparam logic [6:0] PCT_K [NUM_PCT] = '{7'd50, 7'd95, 7'd99};
   localparam logic [6:0] RANK_ROUND = 7'd99;

   // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
   localparam int          DIV100_SHIFT = 37;

   localparam int MEAN_FRAC_BITS = 8;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] sample_us;
   } req_type;

   typedef struct packed {
      logic [10:0] sample_total;
      logic [31:0] p50_us;
      logic [31:0] p95_us;
      logic [31:0] p99_us;
      logic [31:0] min_us;
      logic [31:0] max_us;
      logic [39:0] mean_q8;
      logic        empty_flag;
      logic        dropped_flag;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_RANK,
      ST_SWEEP,
      ST_WAIT_DIV
   } state_type;

endpackage

### design/lps_div.sv
// Module: restoring divider, one quotient bit per cycle, for the Q8 mean.
`timescale 1ns / 1ps

module lps_div #(
   parameter int DVD_BITS = 50,
   parameter int DVS_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                done,
   output logic [DVD_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_BITS + 1);

   logic                busy_ff, done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [DVS_BITS:0]   trial;
   logic                ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_BITS-1]};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? DVS_BITS'(trial - {1'b0, dvs_ff}) : DVS_BITS'(trial);
      quo_in = {quo_ff[DVD_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DVD_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/latency_percentile_stats.sv
// Module: top level of the latency percentile statistics block.
`timescale 1ns / 1ps

// Latency percentile statistics. Issue an item with start while busy is low.
// A record item stores one sample (saturated to the store width) as it is
// accepted, and records may follow back to back; a sample beyond CAPACITY is
// dropped and sets the sticky dropped flag. A clear item also leaves busy
// low. A report item raises busy and produces one result strobe on
// rsp_valid, held for exactly one cycle; the receiver cannot stall it, so
// capture the result when the strobe is seen. A report on an empty store
// returns from ST_START with the empty flag set. Otherwise the percentiles
// come from a bitwise radix select that sweeps the sample memory once per
// value bit through its single read port, while the mean divider runs
// alongside; ST_WAIT_DIV holds the result until the divider is done. Min and
// max are tracked as samples arrive.

module latency_percentile_stats #(
   parameter int CAPACITY    = lps_pkg::CAPACITY_DEF,
   parameter int SAMPLE_BITS = lps_pkg::SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lps_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output lps_pkg::rsp_type rsp_item
);

   localparam int SB        = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SUM_BITS  = SB + CNT_BITS;
   localparam int DVD_BITS  = SUM_BITS + lps_pkg::MEAN_FRAC_BITS;
   localparam int XW        = CNT_BITS + 7;
   localparam int PW        = XW + 32;
   localparam int NP        = lps_pkg::NUM_PCT;

   // sample memory: one write port (record), one registered read port (sweep)
   logic [SB-1:0] mem [CAPACITY];

   lps_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic                ovf_ff, ovf_in;
   logic [SB-1:0]       min_ff, min_in, max_ff, max_in;
   logic [XW-1:0]       x_ff [NP];
   logic [XW-1:0]       x_in [NP];
   logic [XW-1:0]       q_ff [NP];
   logic [XW-1:0]       q_in [NP];
   logic [CNT_BITS-1:0] rank_ff [NP];
   logic [CNT_BITS-1:0] rank_in [NP];
   logic [CNT_BITS-1:0] cnt_ff [NP];
   logic [CNT_BITS-1:0] cnt_in [NP];
   logic [SB-1:0]       prefix_ff [NP];
   logic [SB-1:0]       prefix_in [NP];
   logic [SB-1:0]       mask_ff, mask_in, mask_lsb;
   logic [CNT_BITS-1:0] addr_ff, addr_in;
   logic                rd_vld_ff;
   logic [SB-1:0]       rd_data_ff;
   logic                rd_en, wr_en;
   logic [SB-1:0]       sample_sat;
   logic                accept;
   logic                rsp_valid_ff, rsp_valid_in;
   lps_pkg::rsp_type    rsp_ff, rsp_in;
   logic                div_start, div_done;
   logic [DVD_BITS-1:0] div_quo;
   logic [PW-1:0]       prod [NP];
   logic [XW-1:0]       pos [NP];

   lps_div #(
      .DVD_BITS(DVD_BITS),
      .DVS_BITS(CNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, lps_pkg::MEAN_FRAC_BITS'(0)}),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept     = start && (state_ff == lps_pkg::ST_IDLE);
   // saturate samples wider than the store
   assign sample_sat = ((req_item.sample_us >> SB) != '0) ? '1 : req_item.sample_us[SB-1:0];
   assign wr_en      = accept && (req_item.req_type == lps_pkg::REQ_RECORD)
                       && (fill_ff < CNT_BITS'(CAPACITY));
   assign mask_lsb   = mask_ff & ~{mask_ff[SB-2:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mask_in      = mask_ff;
      addr_in      = addr_ff;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      for (int t = 0; t < NP; t++) begin
         x_in[t]      = x_ff[t];
         q_in[t]      = q_ff[t];
         rank_in[t]   = rank_ff[t];
         cnt_in[t]    = cnt_ff[t];
         prefix_in[t] = prefix_ff[t];
         prod[t]      = PW'(x_ff[t]) * PW'(lps_pkg::DIV100_MAGIC);
         pos[t]       = (q_ff[t] == '0) ? '0 : q_ff[t] - XW'(1);
      end

      unique case (state_ff)
         lps_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_item.req_type)
                  lps_pkg::REQ_RECORD: begin
                     if (wr_en) begin
                        fill_in = fill_ff + CNT_BITS'(1);
                        sum_in  = sum_ff + SUM_BITS'(sample_sat);
                        if (fill_ff == '0 || sample_sat < min_ff) min_in = sample_sat;
                        if (fill_ff == '0 || sample_sat > max_ff) max_in = sample_sat;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  lps_pkg::REQ_REPORT: state_in = lps_pkg::ST_START;
                  lps_pkg::REQ_CLEAR: begin
                     fill_in = '0;
                     sum_in  = '0;
                     ovf_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         lps_pkg::ST_START: begin
            if (fill_ff == '0) begin
               rsp_in              = '0;
               rsp_in.empty_flag   = 1'b1;
               rsp_in.dropped_flag = ovf_ff;
               rsp_valid_in        = 1'b1;
               state_in            = lps_pkg::ST_IDLE;
            end else begin
               div_start = 1'b1;
               for (int t = 0; t < NP; t++) begin
                  x_in[t] = XW'(fill_ff) * XW'(lps_pkg::PCT_K[t]) + XW'(lps_pkg::RANK_ROUND);
               end
               state_in = lps_pkg::ST_MUL;
            end
         end
         lps_pkg::ST_MUL: begin
            for (int t = 0; t < NP; t++) begin
               q_in[t] = XW'(prod[t] >> lps_pkg::DIV100_SHIFT);
            end
            state_in = lps_pkg::ST_RANK;
         end
         lps_pkg::ST_RANK: begin
            // clamp each position to the last sample, open the first bit sweep
            for (int t = 0; t < NP; t++) begin
               rank_in[t]   = (pos[t] > XW'(fill_ff - CNT_BITS'(1)))
                              ? fill_ff - CNT_BITS'(1) : CNT_BITS'(pos[t]);
               prefix_in[t] = '0;
               cnt_in[t]    = '0;
            end
            mask_in  = SB'(1) << (SB - 1);
            addr_in  = '0;
            state_in = lps_pkg::ST_SWEEP;
         end
         lps_pkg::ST_SWEEP: begin
            rd_en = addr_ff < fill_ff;
            if (rd_en) addr_in = addr_ff + CNT_BITS'(1);
            if (rd_vld_ff) begin
               for (int t = 0; t < NP; t++) begin
                  if (((rd_data_ff ^ prefix_ff[t]) & mask_ff) == '0)
                     cnt_in[t] = cnt_ff[t] + CNT_BITS'(1);
               end
            end else if (!rd_en) begin
               // sweep done: fix this bit of each percentile
               for (int t = 0; t < NP; t++) begin
                  if (rank_ff[t] >= cnt_ff[t]) begin
                     prefix_in[t] = prefix_ff[t] | mask_lsb;
                     rank_in[t]   = rank_ff[t] - cnt_ff[t];
                  end
                  cnt_in[t] = '0;
               end
               addr_in = '0;
               mask_in = {1'b1, mask_ff[SB-1:1]};
               if (mask_ff[0]) state_in = lps_pkg::ST_WAIT_DIV;
            end
         end
         lps_pkg::ST_WAIT_DIV: begin
            if (div_done) begin
               rsp_in.sample_total = 11'(fill_ff);
               rsp_in.p50_us       = 32'(prefix_ff[0]);
               rsp_in.p95_us       = 32'(prefix_ff[1]);
               rsp_in.p99_us       = 32'(prefix_ff[2]);
               rsp_in.min_us       = 32'(min_ff);
               rsp_in.max_us       = 32'(max_ff);
               rsp_in.mean_q8      = 40'(div_quo);
               rsp_in.empty_flag   = 1'b0;
               rsp_in.dropped_flag = ovf_ff;
               rsp_valid_in        = 1'b1;
               state_in            = lps_pkg::ST_IDLE;
            end
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lps_pkg::ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
         addr_ff      <= addr_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      max_ff  <= max_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
      for (int t = 0; t < NP; t++) begin
         x_ff[t]      <= x_in[t];
         q_ff[t]      <= q_in[t];
         rank_ff[t]   <= rank_in[t];
         cnt_ff[t]    <= cnt_in[t];
         prefix_ff[t] <= prefix_in[t];
      end
   end

   // sample memory; busy keeps records and sweeps apart
   always_ff @(posedge clock) begin
      if (wr_en) mem[fill_ff[ADDR_BITS-1:0]] <= sample_sat;
      if (rd_en) rd_data_ff <= mem[addr_ff[ADDR_BITS-1:0]];
   end

   assign busy      = state_ff != lps_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### design/lps_checker.sv
// Module: port-level checker for the latency percentile block, with its bind.
`timescale 1ns / 1ps

module lps_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input lps_pkg::req_type req_item,
   input logic             busy,
   input logic             rsp_valid,
   input lps_pkg::rsp_type rsp_item
);

   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.req_type == lps_pkg::REQ_REPORT |=> busy)
      else $error("report item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.empty_flag |-> rsp_item.sample_total == '0 &&
      rsp_item.p99_us == '0 && rsp_item.max_us == '0 && rsp_item.mean_q8 == '0)
      else $error("empty report carried nonzero values");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.empty_flag |->
      rsp_item.min_us <= rsp_item.p50_us && rsp_item.p50_us <= rsp_item.p95_us &&
      rsp_item.p95_us <= rsp_item.p99_us && rsp_item.p99_us <= rsp_item.max_us)
      else $error("percentiles out of order");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind latency_percentile_stats lps_checker u_lps_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .req_item (req_item),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);
